### design/tsq_pkg.sv
// tsq_pkg: shared types and constants of the thick segment to quad block
// no dependencies
package tsq_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COORD_FRAC_DEF  = 16;
  localparam int ID_W            = 16;
  localparam int NORM_W          = 31;
  localparam int SQ_STEPS        = 31;
  localparam int DIV_STEPS       = 31;

  // cell operation codes
  localparam logic [1:0] CELL_PASS = 2'd0;
  localparam logic [1:0] CELL_SQRT = 2'd1;
  localparam logic [1:0] CELL_DIV  = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] start_y;
    logic signed [COORD_WIDTH_DEF-1:0] start_z;
    logic signed [COORD_WIDTH_DEF-1:0] end_y;
    logic signed [COORD_WIDTH_DEF-1:0] end_z;
    logic signed [COORD_WIDTH_DEF-1:0] plate_thickness;
    logic [ID_W-1:0]                   plate_id;
    logic [ID_W-1:0]                   material_id;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] corner_y;
    logic signed [COORD_WIDTH_DEF-1:0] corner_z;
    logic [1:0]                        corner_index;
    logic signed [COORD_WIDTH_DEF-1:0] box_min_y;
    logic signed [COORD_WIDTH_DEF-1:0] box_max_y;
    logic signed [COORD_WIDTH_DEF-1:0] box_min_z;
    logic signed [COORD_WIDTH_DEF-1:0] box_max_z;
    logic [ID_W-1:0]                   out_plate_id;
    logic [ID_W-1:0]                   out_material_id;
    logic                              degenerate;
    logic                              last;
  } out_item_t;

endpackage

### design/tsq_cell.sv
// tsq_cell: one stage of the work chain, one step of the shared square root and divide recurrences
// depends on tsq_pkg
module tsq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 v_in,
  input  logic [1:0]           mode,
  input  logic [63:0]          rem_in,
  input  logic [63:0]          acc_in,
  input  logic [63:0]          aux_in,
  input  logic [63:0]          aux2_in,
  input  logic [5:0]           idx,
  output logic                 v_out,
  output logic [63:0]          rem_out,
  output logic [63:0]          acc_out,
  output logic [63:0]          aux_out,
  output logic [63:0]          aux2_out
);
  // pass, isqrt step, or restoring divide step of two dividends
  logic [63:0] rem_nxt, acc_nxt, aux_nxt, aux2_nxt;
  logic [63:0] bitv, trial, d2, t1, t2;
  logic        v_r;
  logic [63:0] rem_r, acc_r, aux_r, aux2_r;

  always_comb begin
    rem_nxt  = rem_in;
    acc_nxt  = acc_in;
    aux_nxt  = aux_in;
    aux2_nxt = aux2_in;
    bitv     = 64'd1 << {idx, 1'b0};
    trial    = acc_in + bitv;
    d2       = 64'(aux2_in[31:0]);
    t1       = 64'd0;
    t2       = 64'd0;
    unique case (mode)
      tsq_pkg::CELL_SQRT: begin
        if (rem_in >= trial) begin
          rem_nxt = rem_in - trial;
          acc_nxt = (acc_in >> 1) + bitv;
        end else begin
          acc_nxt = acc_in >> 1;
        end
      end
      tsq_pkg::CELL_DIV: begin
        // rem_in holds remainder a, aux_in remainder b, acc dividend and quotient bits a|b
        t1 = {rem_in[62:0], acc_in[62]};
        t2 = {aux_in[62:0], acc_in[30]};
        if (t1 >= d2) begin
          rem_nxt = t1 - d2;
          acc_nxt[63:32] = {acc_in[62:32], 1'b1};
        end else begin
          rem_nxt = t1;
          acc_nxt[63:32] = {acc_in[62:32], 1'b0};
        end
        if (t2 >= d2) begin
          aux_nxt = t2 - d2;
          acc_nxt[31:0] = {acc_in[30:0], 1'b1};
        end else begin
          aux_nxt = t2;
          acc_nxt[31:0] = {acc_in[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    aux_r  <= aux_nxt;
    aux2_r <= aux2_nxt;
  end

  assign v_out    = v_r;
  assign rem_out  = rem_r;
  assign acc_out  = acc_r;
  assign aux_out  = aux_r;
  assign aux2_out = aux2_r;
endmodule

### design/thick_segment_to_quad_bbox.sv
// thick_segment_to_quad_bbox: top level, plate segment in, four quad corners with box out
// depends on tsq_pkg and tsq_cell
//
// usage: drive in_item with start high while busy is low; the transfer happens at that edge.
// each segment travels down a chain of cells: normalize, 31 square root steps,
// 31 divide steps (both unit components in parallel), offset multiply, corner and box stages.
// the chain takes a new segment only while busy is low: busy rises after each transfer and
// stays high until the output sequencer can take the next four results without overlap.
// out_valid first rises once the segment has passed stages 0 and 1, the cells, the offset
// and corner stages and the output sequencer; the chain length, not the data, fixes this.
// results appear on out_item with out_valid high for exactly one cycle each: four corners
// in index order with last on the fourth, or one degenerate result with last set.
// the four corners wait in a holding register at the chain end and leave one per cycle;
// the receiver cannot stall, so nothing backs up.
// reset (rst_n low, synchronous) empties the chain and the output sequencer.
module thick_segment_to_quad_bbox (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tsq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tsq_pkg::out_item_t  out_item
);
  localparam int NC = tsq_pkg::SQ_STEPS + tsq_pkg::DIV_STEPS;

  // input slot pacing
  logic [1:0] slot_r, slot_nxt;
  logic       take;
  assign take = start && !busy;
  assign busy = (slot_r != 2'd0);
  always_comb begin
    slot_nxt = slot_r;
    if (take) slot_nxt = 2'd3;
    else if (slot_r != 2'd0) slot_nxt = slot_r - 2'd1;
  end

  // stage 0: differences, degenerate test
  logic        s0_v_r, s0_dg_r;
  tsq_pkg::in_item_t s0_it_r;
  logic [32:0] s0_a_r, s0_b_r;
  logic signed [32:0] dy, dz;
  logic [32:0] ma, mb;
  always_comb begin
    dy = 33'(in_item.end_y) - 33'(in_item.start_y);
    dz = 33'(in_item.end_z) - 33'(in_item.start_z);
    ma = dy[32] ? 33'(-dy) : 33'(dy);
    mb = dz[32] ? 33'(-dz) : 33'(dz);
  end

  // stage 1: normalize so the larger lies in [2^29, 2^30)
  logic [32:0] mx;
  logic [5:0]  lz;
  logic [30:0] na, nb;
  always_comb begin
    mx = (s0_a_r > s0_b_r) ? s0_a_r : s0_b_r;
    lz = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (mx[i]) lz = 6'(i);
    end
    if (lz >= 6'd29) begin
      na = 31'(s0_a_r >> (lz - 6'd29));
      nb = 31'(s0_b_r >> (lz - 6'd29));
    end else begin
      na = 31'(s0_a_r << (6'd29 - lz));
      nb = 31'(s0_b_r << (6'd29 - lz));
    end
  end

  logic        s1_v_r, s1_dg_r;
  tsq_pkg::in_item_t s1_it_r;
  logic [30:0] s1_a_r, s1_b_r;
  logic        s1_sy_r, s1_sz_r, s0_sy_r, s0_sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      s0_v_r <= take;
      s1_v_r <= s0_v_r;
    end
    s0_it_r <= in_item;
    s0_a_r  <= ma;
    s0_b_r  <= mb;
    s0_sy_r <= dy[32];
    s0_sz_r <= dz[32];
    s0_dg_r <= (in_item.plate_thickness <= 0) || (dy == 0 && dz == 0);
    s1_it_r <= s0_it_r;
    s1_dg_r <= s0_dg_r;
    s1_a_r  <= na;
    s1_b_r  <= nb;
    s1_sy_r <= s0_sy_r;
    s1_sz_r <= s0_sz_r;
  end

  // side data riding along the chain
  typedef struct packed {
    tsq_pkg::in_item_t it;
    logic              dg;
    logic              sy;
    logic              sz;
    logic [30:0]       a;
    logic [30:0]       b;
  } side_t;

  logic [NC:0]       cv;
  logic [63:0]       crem [NC+1];
  logic [63:0]       cacc [NC+1];
  logic [63:0]       caux [NC+1];
  logic [63:0]       caux2[NC+1];
  side_t             cside[NC+1];
  side_t             s1_side;

  assign s1_side = '{it: s1_it_r, dg: s1_dg_r, sy: s1_sy_r, sz: s1_sz_r,
                     a: s1_a_r, b: s1_b_r};
  assign cv[0]    = s1_v_r;
  assign crem[0]  = 64'(s1_a_r) * 64'(s1_a_r) + 64'(s1_b_r) * 64'(s1_b_r);
  assign cacc[0]  = 64'd0;
  assign caux[0]  = 64'd0;
  assign caux2[0] = 64'd0;
  assign cside[0] = s1_side;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic [1:0]  md;
    logic [5:0]  ix;
    logic [63:0] ri, ai, xi, x2i;
    side_t       sd_r;
    if (g < tsq_pkg::SQ_STEPS) begin : g_sq
      assign md  = tsq_pkg::CELL_SQRT;
      assign ix  = 6'(tsq_pkg::SQ_STEPS - 1 - g);
      assign ri  = crem[g];
      assign ai  = cacc[g];
      assign xi  = caux[g];
      assign x2i = caux2[g];
    end else if (g == tsq_pkg::SQ_STEPS) begin : g_dv0
      // start division: a<<30 + len/2 and b<<30 + len/2 divided by len; the upper part
      // is already below len, so it is the first remainder and 31 quotient bits follow
      logic [63:0] na0, nb0;
      assign na0 = (64'(cside[g].a) << 30) + 64'(cacc[g][31:1]);
      assign nb0 = (64'(cside[g].b) << 30) + 64'(cacc[g][31:1]);
      assign md  = tsq_pkg::CELL_DIV;
      assign ix  = 6'd0;
      assign ri  = na0 >> 31;
      assign ai  = {1'b0, na0[30:0], 1'b0, nb0[30:0]};
      assign xi  = nb0 >> 31;
      assign x2i = 64'(cacc[g][31:0]);
    end else begin : g_dv
      assign md  = tsq_pkg::CELL_DIV;
      assign ix  = 6'd0;
      assign ri  = crem[g];
      assign ai  = cacc[g];
      assign xi  = caux[g];
      assign x2i = caux2[g];
    end
    tsq_cell u_cell (
      .clk, .rst_n, .v_in(cv[g]), .mode(md), .rem_in(ri), .acc_in(ai),
      .aux_in(xi), .aux2_in(x2i), .idx(ix), .v_out(cv[g+1]), .rem_out(crem[g+1]),
      .acc_out(cacc[g+1]), .aux_out(caux[g+1]), .aux2_out(caux2[g+1])
    );
    always_ff @(posedge clk) begin
      sd_r <= cside[g];
    end
    assign cside[g+1] = sd_r;
  end

  // the divide cells shift the dividend bits in from acc's low parts: quotient bits
  // replace them one by one, so after 31 steps acc holds the two quotients
  logic [31:0] ua, ub;
  assign ua = {1'b0, cacc[NC][62:32]};
  assign ub = {1'b0, cacc[NC][30:0]};

  // offset stage: magnitude of n*t/2^31, rounded half up
  logic        m_v_r;
  side_t       m_sd_r;
  logic [62:0] m_py_r, m_pz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else        m_v_r <= cv[NC];
    m_sd_r <= cside[NC];
    m_py_r <= 63'(ub) * 63'(cside[NC].it.plate_thickness[30:0]);
    m_pz_r <= 63'(ua) * 63'(cside[NC].it.plate_thickness[30:0]);
  end

  logic signed [34:0] oy, oz;
  logic [33:0] ofy, ofz;
  always_comb begin
    ofy = 34'((m_py_r + 63'(1 << 30)) >> 31);
    ofz = 34'((m_pz_r + 63'(1 << 30)) >> 31);
    // oy = offset(-uz), oz = offset(uy)
    oy  = m_sd_r.sz ? $signed({1'b0, ofy}) : -$signed({1'b0, ofy});
    oz  = m_sd_r.sy ? -$signed({1'b0, ofz}) : $signed({1'b0, ofz});
  end

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sh07FFFFFFF)       return 32'sh7FFFFFFF;
    else if (x < -36'sh080000000) return 32'sh80000000;
    else                          return 32'(x);
  endfunction

  logic        c_v_r;
  side_t       c_sd_r;
  logic signed [31:0] c_y_r [4];
  logic signed [31:0] c_z_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= m_v_r;
    c_sd_r   <= m_sd_r;
    c_y_r[0] <= sat32(36'(m_sd_r.it.start_y) + 36'(oy));
    c_z_r[0] <= sat32(36'(m_sd_r.it.start_z) + 36'(oz));
    c_y_r[1] <= sat32(36'(m_sd_r.it.end_y) + 36'(oy));
    c_z_r[1] <= sat32(36'(m_sd_r.it.end_z) + 36'(oz));
    c_y_r[2] <= sat32(36'(m_sd_r.it.end_y) - 36'(oy));
    c_z_r[2] <= sat32(36'(m_sd_r.it.end_z) - 36'(oz));
    c_y_r[3] <= sat32(36'(m_sd_r.it.start_y) - 36'(oy));
    c_z_r[3] <= sat32(36'(m_sd_r.it.start_z) - 36'(oz));
  end

  // box stage
  logic signed [31:0] mny, mxy, mnz, mxz;
  always_comb begin
    mny = c_y_r[0]; mxy = c_y_r[0]; mnz = c_z_r[0]; mxz = c_z_r[0];
    for (int k = 1; k < 4; k++) begin
      if (c_y_r[k] < mny) mny = c_y_r[k];
      if (c_y_r[k] > mxy) mxy = c_y_r[k];
      if (c_z_r[k] < mnz) mnz = c_z_r[k];
      if (c_z_r[k] > mxz) mxz = c_z_r[k];
    end
  end

  // output sequencer: one corner per cycle
  side_t       b_sd_r;
  logic signed [31:0] b_y_r [4];
  logic signed [31:0] b_z_r [4];
  logic signed [31:0] b_box_r [4];
  logic [2:0]  cnt_r, cnt_nxt;
  tsq_pkg::out_item_t o_r, o_nxt;
  logic        ov_r, ov_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    ov_nxt  = 1'b0;
    o_nxt   = o_r;
    if (c_v_r) cnt_nxt = 3'd4;
    else if (cnt_r != 3'd0) cnt_nxt = cnt_r - 3'd1;
    if (cnt_r != 3'd0) begin
      ov_nxt = !(b_sd_r.dg && cnt_r != 3'd4);
      o_nxt.corner_index    = 2'(3'd4 - cnt_r);
      o_nxt.corner_y        = b_y_r[2'(3'd4 - cnt_r)];
      o_nxt.corner_z        = b_z_r[2'(3'd4 - cnt_r)];
      o_nxt.box_min_y       = b_box_r[0];
      o_nxt.box_max_y       = b_box_r[1];
      o_nxt.box_min_z       = b_box_r[2];
      o_nxt.box_max_z       = b_box_r[3];
      o_nxt.out_plate_id    = b_sd_r.it.plate_id;
      o_nxt.out_material_id = b_sd_r.it.material_id;
      o_nxt.degenerate      = b_sd_r.dg;
      o_nxt.last            = b_sd_r.dg || (cnt_r == 3'd1);
      if (b_sd_r.dg) begin
        o_nxt.corner_index = 2'd0;
        o_nxt.corner_y     = '0;
        o_nxt.corner_z     = '0;
        o_nxt.box_min_y    = '0;
        o_nxt.box_max_y    = '0;
        o_nxt.box_min_z    = '0;
        o_nxt.box_max_z    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    o_r <= o_nxt;
    if (c_v_r) begin
      b_sd_r     <= c_sd_r;
      b_y_r      <= c_y_r;
      b_z_r      <= c_z_r;
      b_box_r[0] <= mny;
      b_box_r[1] <= mxy;
      b_box_r[2] <= mnz;
      b_box_r[3] <= mxz;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = o_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy) else $error("busy not raised after transfer");
  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |=> out_valid) else $error("corner run broken");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |-> (out_item.last && out_item.corner_y == 0))
    else $error("degenerate result malformed");
endmodule

### tb/thick_segment_to_quad_bbox_check.sv
// corner checker for thick_segment_to_quad_bbox: watches segment transfers and corner results,
// predicts the quad corners and box, and counts mismatches; depends on tsq_pkg
`timescale 1ns / 100ps

module thick_segment_to_quad_bbox_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tsq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  tsq_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending_corners,
  output int                 corners_seen,
  output int                 degenerate_seen
);
  localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

  tsq_pkg::out_item_t corner_queue[$];

  initial begin
    fail_count = 0;
    corners_seen = 0;
    degenerate_seen = 0;
  end

  assign pending_corners = corner_queue.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] half_thick_offset(logic signed [63:0] n,
                                                           logic signed [63:0] t);
    logic [63:0] mn;
    logic [63:0] mag;
    mn = (n < 0) ? -n : n;
    mag = mn * (t >>> 31) + ((mn * (t & 64'h7fff_ffff) + (64'd1 << 30)) >> 31);
    return (n < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] clamp_coord(logic signed [63:0] x);
    if (x > COORD_MAX) return COORD_MAX[31:0];
    if (x < COORD_MIN) return COORD_MIN[31:0];
    return x[31:0];
  endfunction

  task automatic predict_quad(tsq_pkg::in_item_t s);
    logic signed [63:0] sy, sz, ey, ez, t, dy, dz, uy, uz, oy, oz;
    logic [63:0] a, b, m, len, ua, ub;
    logic signed [31:0] cy[4];
    logic signed [31:0] cz[4];
    tsq_pkg::out_item_t r;
    sy = s.start_y; sz = s.start_z; ey = s.end_y; ez = s.end_z;
    t = s.plate_thickness;
    dy = ey - sy; dz = ez - sz;
    r = '0;
    r.out_plate_id = s.plate_id;
    r.out_material_id = s.material_id;
    if (t <= 0 || (dy == 0 && dz == 0)) begin
      r.degenerate = 1'b1;
      r.last = 1'b1;
      corner_queue.push_back(r);
      return;
    end
    a = (dy < 0) ? -dy : dy;
    b = (dz < 0) ? -dz : dz;
    m = (a > b) ? a : b;
    while (m >= (64'd1 << 30)) begin
      a = a >> 1; b = b >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      a = a << 1; b = b << 1; m = m << 1;
    end
    len = int_sqrt(a * a + b * b);
    ua = ((a << 30) + (len >> 1)) / len;
    ub = ((b << 30) + (len >> 1)) / len;
    uy = (dy < 0) ? -$signed(ua) : $signed(ua);
    uz = (dz < 0) ? -$signed(ub) : $signed(ub);
    oy = half_thick_offset(-uz, t);
    oz = half_thick_offset(uy, t);
    cy[0] = clamp_coord(sy + oy); cz[0] = clamp_coord(sz + oz);
    cy[1] = clamp_coord(ey + oy); cz[1] = clamp_coord(ez + oz);
    cy[2] = clamp_coord(ey - oy); cz[2] = clamp_coord(ez - oz);
    cy[3] = clamp_coord(sy - oy); cz[3] = clamp_coord(sz - oz);
    r.box_min_y = cy[0]; r.box_max_y = cy[0];
    r.box_min_z = cz[0]; r.box_max_z = cz[0];
    for (int k = 1; k < 4; k++) begin
      if (cy[k] < r.box_min_y) r.box_min_y = cy[k];
      if (cy[k] > r.box_max_y) r.box_max_y = cy[k];
      if (cz[k] < r.box_min_z) r.box_min_z = cz[k];
      if (cz[k] > r.box_max_z) r.box_max_z = cz[k];
    end
    for (int k = 0; k < 4; k++) begin
      r.corner_y = cy[k];
      r.corner_z = cz[k];
      r.corner_index = k[1:0];
      r.last = (k == 3);
      corner_queue.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_corner(tsq_pkg::out_item_t got);
    tsq_pkg::out_item_t want;
    if (corner_queue.size() == 0) begin
      report_mismatch("unexpected result", got.corner_index, 0);
      return;
    end
    want = corner_queue.pop_front();
    if (got.corner_y !== want.corner_y) report_mismatch("corner_y", got.corner_y, want.corner_y);
    if (got.corner_z !== want.corner_z) report_mismatch("corner_z", got.corner_z, want.corner_z);
    if (got.corner_index !== want.corner_index)
      report_mismatch("corner_index", got.corner_index, want.corner_index);
    if (got.box_min_y !== want.box_min_y)
      report_mismatch("box_min_y", got.box_min_y, want.box_min_y);
    if (got.box_max_y !== want.box_max_y)
      report_mismatch("box_max_y", got.box_max_y, want.box_max_y);
    if (got.box_min_z !== want.box_min_z)
      report_mismatch("box_min_z", got.box_min_z, want.box_min_z);
    if (got.box_max_z !== want.box_max_z)
      report_mismatch("box_max_z", got.box_max_z, want.box_max_z);
    if (got.out_plate_id !== want.out_plate_id)
      report_mismatch("out_plate_id", got.out_plate_id, want.out_plate_id);
    if (got.out_material_id !== want.out_material_id)
      report_mismatch("out_material_id", got.out_material_id, want.out_material_id);
    if (got.degenerate !== want.degenerate)
      report_mismatch("degenerate", got.degenerate, want.degenerate);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    if (want.degenerate) degenerate_seen++;
    else corners_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) predict_quad(in_item);
      if (out_valid) compare_corner(out_item);
    end
  end

endmodule

### tb/thick_segment_to_quad_bbox_test.sv
// testbench top for thick_segment_to_quad_bbox: drives directed and random plate segments
// with random idle bursts; depends on tsq_pkg, the block and thick_segment_to_quad_bbox_check
`timescale 1ns / 100ps

module thick_segment_to_quad_bbox_test;
  localparam int RANDOM_SEGMENTS = 350;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 100;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  tsq_pkg::in_item_t  in_item;
  logic      out_valid;
  tsq_pkg::out_item_t out_item;
  int        fail_count;
  int        pending_corners;
  int        corners_seen;
  int        degenerate_seen;
  int        idle_cycles;
  int        segments_sent;

  thick_segment_to_quad_bbox dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  thick_segment_to_quad_bbox_check checker_inst (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending_corners(pending_corners),
    .corners_seen(corners_seen), .degenerate_seen(degenerate_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no transfer either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_segment(tsq_pkg::in_item_t s, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    segments_sent++;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic tsq_pkg::in_item_t random_segment();
    tsq_pkg::in_item_t s;
    s.start_y = random_coord();
    s.start_z = random_coord();
    s.end_y = random_coord();
    s.end_z = random_coord();
    case ($urandom_range(0, 9))
      0: s.end_y = s.start_y;
      1: s.end_z = s.start_z;
      2: begin
        s.end_y = s.start_y;
        s.end_z = s.start_z;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: s.plate_thickness = 32'(-$signed({1'b0, $urandom_range(0, 32'h7fff_ffff)}));
      1: s.plate_thickness = $urandom();
      2: s.plate_thickness = 32'h7fff_ffff;
      default: s.plate_thickness = $urandom_range(1, 32'h0010_0000);
    endcase
    s.plate_id = $urandom();
    s.material_id = $urandom();
    return s;
  endfunction

  function automatic tsq_pkg::in_item_t make_segment(logic [31:0] sy, logic [31:0] sz,
                                                     logic [31:0] ey, logic [31:0] ez,
                                                     logic [31:0] t,
                                                     logic [15:0] pid, logic [15:0] mid);
    tsq_pkg::in_item_t s;
    s.start_y = sy; s.start_z = sz; s.end_y = ey; s.end_z = ez;
    s.plate_thickness = t; s.plate_id = pid; s.material_id = mid;
    return s;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    idle_cycles = 0;
    segments_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // horizontal, vertical, diagonal
    send_segment(make_segment(0, 0, 32'h000a_0000, 0, 32'h0002_0000, 16'h0001, 16'h0002), 0);
    send_segment(make_segment(0, 0, 0, 32'h000a_0000, 32'h0002_0000, 16'hffff, 16'h0000), 0);
    send_segment(make_segment(32'hfff0_0000, 32'h0010_0000, 32'h0010_0000, 32'hfff0_0000,
                              32'h0001_0000, 16'h0000, 16'hffff), 0);
    // tiny length and minimum thickness
    send_segment(make_segment(5, 7, 6, 7, 1, 16'h1234, 16'h5678), 0);
    send_segment(make_segment(0, 0, 0, -1, 1, 16'h8000, 16'h0001), 0);
    // zero length, zero and negative thickness
    send_segment(make_segment(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                              32'h0001_0000, 16'h00aa, 16'h0055), 0);
    send_segment(make_segment(0, 0, 32'h0001_0000, 0, 0, 16'h0101, 16'h0202), 0);
    send_segment(make_segment(0, 0, 32'h0001_0000, 0, 32'h8000_0000, 16'h0303, 16'h0404), 0);
    send_segment(make_segment(0, 0, 32'h0001_0000, 0, 32'hffff_ffff, 16'h0505, 16'h0606), 0);
    // full range span and saturation at both ends
    send_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 16'hffff, 16'hffff), 0);
    send_segment(make_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                              32'h7fff_ffff, 16'h0000, 16'h0000), 0);
    send_segment(make_segment(32'h7fff_0000, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                              16'h0f0f, 16'hf0f0), 0);
    send_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8001_0000,
                              32'h0100_0000, 16'h7777, 16'h8888), 0);
    send_segment(make_segment(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000,
                              16'h1111, 16'h2222), 0);

    for (int i = 0; i < RANDOM_SEGMENTS; i++)
      send_segment(random_segment(), i < RANDOM_SEGMENTS - 40);
    start <= 1'b0;

    while (pending_corners != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d segments sent, %0d corners and %0d degenerate results checked",
             segments_sent, corners_seen, degenerate_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/tsq_pkg.sv
design/tsq_cell.sv
design/thick_segment_to_quad_bbox.sv
tb/thick_segment_to_quad_bbox_check.sv
tb/thick_segment_to_quad_bbox_test.sv
